>>> design/bcc_pkg.sv
package bcc_pkg;

	// counter and register widths
	localparam int COUNT_WIDTH = 16;
	localparam int CFG_W       = 16;
	localparam int CMP_W       = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
	localparam int IDX_W       = 2;

	// register reset values
	localparam logic [CFG_W-1:0] LONG_PRESS_RST = CFG_W'(100);
	localparam logic [CFG_W-1:0] CLICK_GAP_RST  = CFG_W'(50);
	localparam logic [CFG_W-1:0] COOLDOWN_RST   = CFG_W'(10);

	// register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_LONG_PRESS = 2'd0,
		REG_CLICK_GAP  = 2'd1,
		REG_COOLDOWN   = 2'd2
	} reg_idx_t;

	// event codes
	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_SINGLE = 2'd1,
		EV_DOUBLE = 2'd2,
		EV_LONG   = 2'd3
	} event_t;

	// classifier phase, one-hot
	typedef enum logic [4:0] {
		PH_IDLE      = 5'b00001,
		PH_PRESSED   = 5'b00010,
		PH_RELEASED  = 5'b00100,
		PH_COOLDOWN  = 5'b01000,
		PH_LONG_WAIT = 5'b10000
	} phase_t;

	typedef logic [COUNT_WIDTH-1:0] count_t;

	// thresholds handed from the register block to the classifier
	typedef struct packed {
		logic [CFG_W-1:0] long_press_ticks;
		logic [CFG_W-1:0] click_gap_ticks;
		logic [CFG_W-1:0] cooldown_len;
	} cfg_t;

	// saturating increment
	function automatic count_t sat_inc(input count_t v);
		count_t r;
		r = (v == {COUNT_WIDTH{1'b1}}) ? v : v + count_t'(1);
		return r;
	endfunction

	// counter reaches threshold, compared at a common width
	function automatic logic reached(input count_t cnt, input logic [CFG_W-1:0] thr);
		logic r;
		r = (CMP_W'(cnt) >= CMP_W'(thr));
		return r;
	endfunction

endpackage

>>> design/bcc_cfg.sv
module bcc_cfg
	import bcc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_press_ticks <= LONG_PRESS_RST;
			cfg_q.click_gap_ticks  <= CLICK_GAP_RST;
			cfg_q.cooldown_len     <= COOLDOWN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LONG_PRESS: cfg_q.long_press_ticks <= cfg_data;
				REG_CLICK_GAP:  cfg_q.click_gap_ticks  <= cfg_data;
				REG_COOLDOWN:   cfg_q.cooldown_len     <= cfg_data;
				default:        cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> design/bcc_core.sv
module bcc_core
	import bcc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   step,
	input  logic   pin_level,
	input  cfg_t   cfg,
	output event_t ev
);

	phase_t phase_q, phase_d;
	count_t since_release_q, since_release_d;
	count_t since_press_q, since_press_d;
	count_t cooldown_count_q, cooldown_count_d;
	count_t sr_upd, sp_upd, cc_inc;
	logic   rel;

	// tick counters and phase transition for the current sample
	always_comb begin
		rel    = pin_level;
		sr_upd = rel ? '0 : sat_inc(since_release_q);
		sp_upd = rel ? sat_inc(since_press_q) : '0;
		cc_inc = sat_inc(cooldown_count_q);

		ev               = EV_NONE;
		phase_d          = phase_q;
		since_release_d  = sr_upd;
		since_press_d    = sp_upd;
		cooldown_count_d = cooldown_count_q;

		case (phase_q)
			PH_PRESSED: begin
				if (reached(sr_upd, cfg.long_press_ticks)) begin
					ev      = EV_LONG;
					phase_d = PH_LONG_WAIT;
				end else if (rel) begin
					phase_d = PH_RELEASED;
				end
			end
			PH_RELEASED: begin
				if (reached(sp_upd, cfg.click_gap_ticks)) begin
					ev               = EV_SINGLE;
					phase_d          = PH_COOLDOWN;
					cooldown_count_d = '0;
				end else if (!rel) begin
					ev               = EV_DOUBLE;
					phase_d          = PH_COOLDOWN;
					cooldown_count_d = '0;
				end
			end
			PH_COOLDOWN: begin
				cooldown_count_d = cc_inc;
				if (reached(cc_inc, cfg.cooldown_len)) begin
					phase_d         = PH_IDLE;
					since_release_d = '0;
					since_press_d   = '0;
				end
			end
			PH_LONG_WAIT: begin
				if (rel) begin
					phase_d         = PH_IDLE;
					since_release_d = '0;
					since_press_d   = '0;
				end
			end
			default: begin
				// idle, and any stray code behaves as idle
				phase_d = rel ? PH_IDLE : PH_PRESSED;
			end
		endcase
	end

	// state update once per consumed sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= PH_IDLE;
			since_release_q  <= '0;
			since_press_q    <= '0;
			cooldown_count_q <= '0;
		end else if (step) begin
			phase_q          <= phase_d;
			since_release_q  <= since_release_d;
			since_press_q    <= since_press_d;
			cooldown_count_q <= cooldown_count_d;
		end
	end

	// a long press always parks in the release wait
	a_long_wait: assert property (@(posedge clk) disable iff (!arst_n)
		step && ev == EV_LONG |=> phase_q == PH_LONG_WAIT)
		else $error("long press did not enter release wait");

	// a click starts a fresh cooldown
	a_click_cooldown: assert property (@(posedge clk) disable iff (!arst_n)
		step && (ev == EV_SINGLE || ev == EV_DOUBLE)
		|=> phase_q == PH_COOLDOWN && cooldown_count_q == '0)
		else $error("click did not start cooldown");

	// phase holds while no sample is consumed
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(phase_q) && $stable(since_press_q))
		else $error("state moved without a sample");

endmodule

>>> design/button_click_classifier.sv
// button click classifier
//
// in channel: in_valid / in_ready with pin_level, one button sample per
// item (0 pressed, 1 released). out channel: out_valid / out_ready with
// click_event, exactly one result item per input item (none, single,
// double, long press).
// an accepted item sits in the input register until the result register
// is free or being drained, is classified and lands in the result
// register, which drives out_valid.
// throughput is one item per cycle while out_ready stays high; the single
// classifier stage with its counter compares sets that figure.
// when the receiver stalls, the result register holds, the input register
// fills and in_ready drops; no item is lost or repeated.
// configuration: cfg_we with cfg_index and cfg_data writes the long-press,
// click-gap or cooldown threshold; write only while no item is in flight.
// reset (arst_n low) clears both stages, returns the classifier to idle
// with zeroed counters and loads the default thresholds.
module button_click_classifier
	import bcc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             pin_level,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       click_event,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	cfg_t   cfg;
	event_t ev;
	logic   valid_s1, pin_s1;
	logic   valid_s2;
	event_t event_s2;
	logic   advance;

	bcc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// stage 1 moves on when the result register is free or being drained
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pin_s1 <= pin_level;
		end
	end

	bcc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.pin_level (pin_s1),
		.cfg       (cfg),
		.ev        (ev)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_s2 <= ev;
		end
	end

	assign out_valid   = valid_s2;
	assign click_event = event_s2;

	// a full input stage behind a stalled output blocks new items
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !out_ready |-> !in_ready)
		else $error("input taken while pipeline is full");

	// a classified item always shows up as a result
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid)
		else $error("classified item lost");

endmodule

>>> dv/button_click_classifier_tb.sv
`timescale 1ns / 1ps

module button_click_classifier_tb;
	import bcc_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int PRINT_MAX = 100;
	localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
	localparam logic LVL_PRESSED = 1'b0;
	localparam logic LVL_RELEASED = 1'b1;
	localparam logic [CFG_W-1:0] THR_MAX = {CFG_W{1'b1}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic pin_level = LVL_RELEASED;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] click_event;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	// pending levels and expected events
	logic level_queue[$];
	event_t expected_events[$];
	int levels_queued = 0;
	int events_checked = 0;
	int mismatch_count = 0;
	bit calm = 1'b0;
	logic in_fire = 1'b0;
	int in_gap = 0;
	int out_stall = 0;
	int quiet_cycles = 0;

	// classifier model state and thresholds
	phase_t cls_phase = PH_IDLE;
	count_t held_ticks = '0;
	count_t free_ticks = '0;
	count_t cool_ticks = '0;
	logic [CFG_W-1:0] thr_long = LONG_PRESS_RST;
	logic [CFG_W-1:0] thr_gap = CLICK_GAP_RST;
	logic [CFG_W-1:0] thr_cool = COOLDOWN_RST;

	button_click_classifier dut (.*);

	always #1 clk = ~clk;

	function automatic void return_idle();
		cls_phase = PH_IDLE;
		held_ticks = '0;
		free_ticks = '0;
	endfunction

	// one tick of the classifier, returns the event code for this sample
	function automatic event_t classify(input logic lvl);
		event_t ev;
		logic released;
		ev = EV_NONE;
		released = (lvl == LVL_RELEASED);
		// saturating tick counters
		if (released) begin
			held_ticks = '0;
			if (free_ticks != '1) free_ticks++;
		end else begin
			free_ticks = '0;
			if (held_ticks != '1) held_ticks++;
		end
		case (cls_phase)
			PH_PRESSED: begin
				if (held_ticks >= thr_long) begin
					ev = EV_LONG;
					cls_phase = PH_LONG_WAIT;
				end else if (released) begin
					cls_phase = PH_RELEASED;
				end
			end
			PH_RELEASED: begin
				if (free_ticks >= thr_gap) begin
					ev = EV_SINGLE;
					cls_phase = PH_COOLDOWN;
					cool_ticks = '0;
				end else if (!released) begin
					ev = EV_DOUBLE;
					cls_phase = PH_COOLDOWN;
					cool_ticks = '0;
				end
			end
			PH_COOLDOWN: begin
				if (cool_ticks != '1) cool_ticks++;
				if (cool_ticks >= thr_cool) return_idle();
			end
			PH_LONG_WAIT: begin
				if (released) return_idle();
			end
			default: begin
				if (!released) cls_phase = PH_PRESSED;
			end
		endcase
		return ev;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatch_count < PRINT_MAX) $display("MISMATCH @%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// register write, only issued while nothing is in flight
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_LONG_PRESS: thr_long = val;
			REG_CLICK_GAP: thr_gap = val;
			REG_COOLDOWN: thr_cool = val;
			default: ;
		endcase
	endtask

	task automatic push_run(input logic lvl, input int n);
		repeat (n) begin
			level_queue.push_back(lvl);
			levels_queued++;
		end
	endtask

	// mostly small thresholds, with zero and one now and then
	function automatic logic [CFG_W-1:0] pick_thr();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0) return '0;
		if (r == 1) return CFG_W'(1);
		return CFG_W'($urandom_range(2, 20));
	endfunction

	task automatic random_setting();
		write_reg(REG_LONG_PRESS, pick_thr());
		write_reg(REG_CLICK_GAP, pick_thr());
		write_reg(REG_COOLDOWN, pick_thr());
		write_reg(REG_SPARE, CFG_W'($urandom));
	endtask

	// press and release runs around the thresholds, plus some noise
	task automatic random_gestures(input int n_items);
		int added;
		int n;
		added = 0;
		while (added < n_items) begin
			if ($urandom_range(0, 9) < 2) begin
				n = $urandom_range(1, 8);
				repeat (n) push_run(logic'($urandom_range(0, 1)), 1);
				added += n;
			end else begin
				n = $urandom_range(1, int'(thr_long) + 3);
				push_run(LVL_PRESSED, n);
				added += n;
				n = $urandom_range(1, int'(thr_gap) + 3);
				push_run(LVL_RELEASED, n);
				added += n;
			end
		end
	endtask

	task automatic drain();
		while (events_checked < levels_queued) @(negedge clk);
	endtask

	// item driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_fire) begin
			// hold the item until taken
		end else if (in_gap > 0) begin
			in_valid <= 1'b0;
			in_gap <= in_gap - 1;
		end else if (level_queue.size() > 0) begin
			in_valid <= 1'b1;
			pin_level <= level_queue.pop_front();
			if (!calm && $urandom_range(0, 11) == 0) in_gap <= $urandom_range(1, 15);
		end else begin
			in_valid <= 1'b0;
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		if (out_stall > 0) begin
			out_ready <= 1'b0;
			out_stall <= out_stall - 1;
		end else begin
			out_ready <= 1'b1;
			if (!calm && $urandom_range(0, 11) == 0) out_stall <= $urandom_range(1, 15);
		end
	end

	// monitor: predict on input take, check on output take
	always @(posedge clk) begin
		event_t want;
		in_fire <= in_valid && in_ready;
		if (arst_n) begin
			if (in_valid && in_ready) expected_events.push_back(classify(pin_level));
			if (out_valid && out_ready) begin
				if (expected_events.size() == 0) begin
					report_mismatch($sformatf("unexpected event %0d", click_event));
				end else begin
					want = expected_events.pop_front();
					if (click_event !== want)
						report_mismatch($sformatf("click_event %0d, want %0d (%s)",
							click_event, want, want.name()));
				end
				events_checked++;
			end
		end
	end

	// watchdog on cycles with no item taken
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("button_click_classifier regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// reset thresholds: double click, cooldown, a short press
		write_reg(REG_SPARE, THR_MAX);
		push_run(LVL_RELEASED, 1);
		push_run(LVL_PRESSED, 1);
		push_run(LVL_RELEASED, 1);
		push_run(LVL_PRESSED, 1);
		push_run(LVL_RELEASED, 10);
		push_run(LVL_PRESSED, 2);
		push_run(LVL_RELEASED, 2);
		drain();

		// zero thresholds fire on the first tick of their phase
		write_reg(REG_LONG_PRESS, '0);
		write_reg(REG_CLICK_GAP, '0);
		write_reg(REG_COOLDOWN, '0);
		push_run(LVL_PRESSED, 2);
		push_run(LVL_RELEASED, 1);
		push_run(LVL_PRESSED, 1);
		push_run(LVL_RELEASED, 1);
		drain();
		write_reg(REG_LONG_PRESS, CFG_W'(3));
		push_run(LVL_PRESSED, 1);
		push_run(LVL_RELEASED, 3);
		drain();

		// random settings and gestures
		repeat (4) begin
			random_setting();
			random_gestures(150);
			drain();
		end

		// largest thresholds: no long press, no single click, cooldown stays
		write_reg(REG_LONG_PRESS, THR_MAX);
		write_reg(REG_CLICK_GAP, THR_MAX);
		write_reg(REG_COOLDOWN, THR_MAX);
		push_run(LVL_PRESSED, 40);
		push_run(LVL_RELEASED, 1);
		push_run(LVL_PRESSED, 1);
		push_run(LVL_RELEASED, 30);
		drain();

		// final stretch without idling
		calm = 1'b1;
		random_setting();
		random_gestures(150);
		drain();

		repeat (8) @(posedge clk);
		if (expected_events.size() != 0)
			report_mismatch($sformatf("%0d events never arrived", expected_events.size()));
		if (mismatch_count == 0) begin
			$display("button_click_classifier regression: pass");
		end else begin
			$display("button_click_classifier regression: fail");
		end
		$finish;
	end

endmodule

>>> filelist.f
design/bcc_pkg.sv
design/bcc_cfg.sv
design/bcc_core.sv
design/button_click_classifier.sv
dv/button_click_classifier_tb.sv
